// ----- design/rade_pkg.sv -----
// Shared types, constants and helper functions for the RSSI average distance estimator.
// Depends on nothing; every other design file but rade_ram refers to it by scoped names.

package rade_pkg;

    // Sample ring geometry.
    localparam int DEPTH  = 16;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int SUM_W  = 8 + $clog2(DEPTH);

    // Shared bit-serial divider.
    localparam int DIV_W  = 42;
    localparam int DEN_W  = 7;
    localparam int ITER_W = $clog2(DIV_W + 1);

    // Exponent split: integer part of the Q32 exponent.
    localparam int N_W = DIV_W + 1 - 32;
    localparam logic signed [N_W-1:0] N_HUGE = 11'sd18;
    localparam logic signed [N_W-1:0] N_TINY = -11'sd9;

    // Series for 2^f: number of terms, term index width, Q30 one.
    localparam int TERMS = 16;
    localparam int K_W   = 5;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Fixed-point constants.
    localparam logic [33:0] LOG2_10_Q32 = 34'h3_5269_E12F;
    localparam logic [31:0] LN2_Q32     = 32'hB172_17F8;
    localparam logic [23:0] DIST_MAX    = 24'hFF_FFFF;
    localparam logic [5:0]  FRAC_Q      = 6'd30;
    localparam logic [39:0] CM_PER_M    = 40'd100;

    // Configuration registers and their reset values.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;
    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_REF    = 2'd1;
    localparam logic [1:0] REG_PLD    = 2'd2;
    localparam logic signed [7:0] REF_RSSI_RST = -8'sd56;
    localparam logic [6:0]        PLD_RST      = 7'd21;

    // Queue between the front and back parts.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Channel payloads.
    typedef struct packed {
        logic [47:0]       device_address;
        logic signed [7:0] rssi;
    } t_in;

    typedef struct packed {
        logic signed [7:0] mean_rssi;
        logic [23:0]       distance_cm;
    } t_out;

    // Settings the back part needs from the register file.
    typedef struct packed {
        logic signed [7:0] ref_rssi;
        logic [6:0]        path_loss_divisor;
    } t_cfg;

    // Head of the sample queue.
    typedef struct packed {
        logic              valid;
        logic signed [7:0] rssi;
    } t_qhead;

    // Reciprocal ceil(2^34 / k) for the series divisions, exact for x below 2^30.
    function automatic logic [34:0] recip(input logic [K_W-1:0] k);
        logic [34:0] m;
        case (k)
            5'd1:    m = 35'd17179869184;
            5'd2:    m = 35'd8589934592;
            5'd3:    m = 35'd5726623062;
            5'd4:    m = 35'd4294967296;
            5'd5:    m = 35'd3435973837;
            5'd6:    m = 35'd2863311531;
            5'd7:    m = 35'd2454267027;
            5'd8:    m = 35'd2147483648;
            5'd9:    m = 35'd1908874354;
            5'd10:   m = 35'd1717986919;
            5'd11:   m = 35'd1561806290;
            5'd12:   m = 35'd1431655766;
            5'd13:   m = 35'd1321528399;
            5'd14:   m = 35'd1227133514;
            5'd15:   m = 35'd1145324613;
            5'd16:   m = 35'd1073741824;
            default: m = 35'd0;
        endcase
        return m;
    endfunction

endpackage

// ----- design/rssi_average_distance_estimator.sv -----
// RSSI average distance estimator, top level: front part, sample queue, back part.
// Each matching beat runs through the shared bit-serial divider (12 steps for the mean,
// 42 for the exponent) and, unless the estimate saturates high or low, through the
// 16-term series, each term in the states S_TMUL, S_TREC and S_TACC.
// Matching beats are handled one at a time; other beats are taken while the queue has room.
// Reset (synchronous, active low) clears control state and registers; ring contents stay.

module rssi_average_distance_estimator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rade_pkg::ADDR_W-1:0]   paddr,
    input  logic [rade_pkg::DATA_W-1:0]   pwdata,
    output logic [rade_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rade_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rade_pkg::t_out                o_out_data
);

    rade_pkg::t_qhead w_head;
    rade_pkg::t_cfg   w_cfg;
    logic             w_pop;

    // Register accesses always complete in their access cycle.
    assign pready = 1'b1;

    // Register file, address match and sample queue.
    rade_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_cfg      (w_cfg)
    );

    // Averaging and distance arithmetic.
    rade_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_cfg       (w_cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- design/rade_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module rade_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/rade_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle, shared by the back part.
// Depends on rade_pkg for its widths.

module rade_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rade_pkg::DIV_W-1:0]   i_num,
    input  logic [rade_pkg::DEN_W-1:0]   i_den,
    input  logic [rade_pkg::ITER_W-1:0]  i_iters,
    output logic                         o_done,
    output logic [rade_pkg::DIV_W-1:0]   o_quot,
    output logic [rade_pkg::DEN_W-1:0]   o_rem
);

    logic [rade_pkg::DIV_W-1:0]  r_num;
    logic [rade_pkg::DEN_W-1:0]  r_rem;
    logic [rade_pkg::DEN_W-1:0]  r_den;
    logic [rade_pkg::ITER_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [rade_pkg::ITER_W-1:0] w_sh;
    logic [rade_pkg::DEN_W:0]    w_trial;
    logic [rade_pkg::DEN_W:0]    w_diff;
    logic                        w_ge;

    // Only the low i_iters bits of the numerator are significant; align them to the top.
    assign w_sh = rade_pkg::ITER_W'(rade_pkg::DIV_W) - i_iters;

    // One restoring step: bring down the next bit and try the subtraction.
    assign w_trial = {r_rem, r_num[rade_pkg::DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num << w_sh;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= i_iters;
                r_busy <= (i_iters != '0);
            end else if (r_busy) begin
                r_num <= {r_num[rade_pkg::DIV_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[rade_pkg::DEN_W-1:0] : w_trial[rade_pkg::DEN_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rade_pkg::ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule

// ----- design/rade_front.sv -----
// Front part: register file, address match and the short sample queue to the back part.
// Depends on rade_pkg for types and register codes.

module rade_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rade_pkg::ADDR_W-1:0]   paddr,
    input  logic [rade_pkg::DATA_W-1:0]   pwdata,
    output logic [rade_pkg::DATA_W-1:0]   prdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rade_pkg::t_in                 i_in_data,
    input  logic                          i_pop,
    output rade_pkg::t_qhead              o_head,
    output rade_pkg::t_cfg                o_cfg
);

    logic [47:0]       r_target;
    logic signed [7:0] r_ref;
    logic [6:0]        r_pld;

    logic signed [7:0]           r_qmem [rade_pkg::Q_DEPTH];
    logic [rade_pkg::Q_PTR_W-1:0] r_rd;
    logic [rade_pkg::Q_PTR_W-1:0] r_wr;
    logic [rade_pkg::Q_CNT_W-1:0] r_cnt;

    logic       w_wr;
    logic [1:0] w_idx;
    logic       w_full;
    logic       w_push;

    assign w_idx = paddr[4:3];
    assign w_wr  = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_ref    <= rade_pkg::REF_RSSI_RST;
            r_pld    <= rade_pkg::PLD_RST;
        end else if (w_wr) begin
            case (w_idx)
                rade_pkg::REG_TARGET: r_target <= pwdata[47:0];
                rade_pkg::REG_REF:    r_ref    <= pwdata[7:0];
                rade_pkg::REG_PLD:    r_pld    <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (w_idx)
            rade_pkg::REG_TARGET: prdata = {16'b0, r_target};
            rade_pkg::REG_REF:    prdata = {56'b0, r_ref};
            rade_pkg::REG_PLD:    prdata = {57'b0, r_pld};
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.ref_rssi          = r_ref;
    assign o_cfg.path_loss_divisor = r_pld;

    // Every beat is taken while the queue has room; only the tracked address is queued.
    assign w_full     = (r_cnt == rade_pkg::Q_CNT_W'(rade_pkg::Q_DEPTH));
    assign o_in_stall = w_full;
    assign w_push     = i_in_valid && !w_full && (i_in_data.device_address == r_target);

    // Sample queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_qmem[r_wr] <= i_in_data.rssi;
                r_wr         <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.rssi  = r_qmem[r_rd];

    // The back part never takes a sample from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("sample popped from empty queue");

endmodule

// ----- design/rade_back.sv -----
// Back part: sample ring, running sum, mean, log-distance estimate and output register.
// Depends on rade_pkg, rade_ram and rade_div.

module rade_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rade_pkg::t_qhead  i_head,
    output logic              o_pop,
    input  rade_pkg::t_cfg    i_cfg,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rade_pkg::t_out    o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MDIV,
        S_MUL,
        S_YDIV,
        S_CLASS,
        S_TMUL,
        S_TREC,
        S_TACC,
        S_SCALE,
        S_OUT
    } t_state;

    t_state                              r_state;
    logic [rade_pkg::PTR_W-1:0]          r_wpos;
    logic [rade_pkg::FILL_W-1:0]         r_fill;
    logic signed [rade_pkg::SUM_W-1:0]   r_sum;
    logic signed [7:0]                   r_new;
    logic                                r_mneg;
    logic signed [7:0]                   r_mean;
    logic                                r_yneg;
    logic signed [rade_pkg::N_W-1:0]     r_n;
    logic [31:0]                         r_f;
    logic [29:0]                         r_z;
    logic [30:0]                         r_term;
    logic [30:0]                         r_psum;
    logic [29:0]                         r_x;
    logic [47:0]                         r_ph;
    logic [46:0]                         r_pl;
    logic [rade_pkg::K_W-1:0]            r_k;
    logic [23:0]                         r_dist;
    logic                                r_div_start;
    logic [rade_pkg::DIV_W-1:0]          r_div_num;
    logic [rade_pkg::DEN_W-1:0]          r_div_den;
    logic [rade_pkg::ITER_W-1:0]         r_div_iters;
    logic                                r_ovalid;
    rade_pkg::t_out                      r_odata;

    logic [7:0]                          w_old;
    logic                                w_full;
    logic signed [rade_pkg::SUM_W-1:0]   w_new_ext;
    logic signed [rade_pkg::SUM_W-1:0]   w_old_ext;
    logic signed [rade_pkg::SUM_W-1:0]   n_sum;
    logic [rade_pkg::SUM_W-1:0]          w_sum_abs;
    logic [rade_pkg::FILL_W-1:0]         n_fill;
    logic                                w_div_done;
    logic [rade_pkg::DIV_W-1:0]          w_div_quot;
    logic [rade_pkg::DEN_W-1:0]          w_div_rem;
    logic [7:0]                          w_mean;
    logic signed [8:0]                   w_diff;
    logic [8:0]                          w_diff_abs;
    logic [rade_pkg::DIV_W-1:0]          w_mag;
    logic [rade_pkg::DIV_W-1:0]          w_qc;
    logic [rade_pkg::DIV_W:0]            w_yrel;
    logic [63:0]                         w_zp;
    logic [60:0]                         w_tp;
    logic [34:0]                         w_m;
    logic [64:0]                         w_prod;
    logic [30:0]                         w_q;
    logic [5:0]                          w_shift;
    logic [39:0]                         w_pw;
    logic [39:0]                         w_rnd;
    logic [39:0]                         w_v;
    logic [23:0]                         w_dist;
    logic                                w_load;

    // Ring: read the slot about to be overwritten, write the new sample in the following cycle.
    rade_ram #(
        .WIDTH (8),
        .DEPTH (rade_pkg::DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_RD),
        .i_waddr (r_wpos),
        .i_wdata (r_new),
        .i_raddr (r_wpos),
        .o_rdata (w_old)
    );

    // Divider shared by the mean and the exponent.
    rade_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .i_iters (r_div_iters),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot),
        .o_rem   (w_div_rem)
    );

    assign o_pop = (r_state == S_IDLE) && i_head.valid;

    // Running sum: once the ring is full the overwritten sample leaves the sum.
    assign w_full    = (r_fill == rade_pkg::FILL_W'(rade_pkg::DEPTH));
    assign w_new_ext = {{(rade_pkg::SUM_W-8){r_new[7]}}, r_new};
    assign w_old_ext = {{(rade_pkg::SUM_W-8){w_old[7]}}, w_old};
    assign n_sum     = r_sum + w_new_ext - (w_full ? w_old_ext : '0);
    assign w_sum_abs = n_sum[rade_pkg::SUM_W-1] ? -n_sum : n_sum;
    assign n_fill    = w_full ? r_fill : r_fill + 1'b1;

    // Mean truncates toward zero: divide the magnitude, then restore the sign.
    assign w_mean = r_mneg ? -w_div_quot[7:0] : w_div_quot[7:0];

    // Exponent magnitude |ref - mean| * log2(10) in Q32.
    assign w_diff     = {i_cfg.ref_rssi[7], i_cfg.ref_rssi} - {r_mean[7], r_mean};
    assign w_diff_abs = w_diff[8] ? -w_diff : w_diff;
    assign w_mag      = {34'b0, w_diff_abs[7:0]} * {8'b0, rade_pkg::LOG2_10_Q32};

    // Negative exponents round the quotient up so the split floors toward minus infinity.
    assign w_qc   = w_div_quot + rade_pkg::DIV_W'(w_div_rem != '0);
    assign w_yrel = r_yneg ? -{1'b0, w_qc} : {1'b0, w_div_quot};

    // Series argument z = f * ln2 in Q30.
    assign w_zp = {32'b0, r_f} * {32'b0, rade_pkg::LN2_Q32};

    // Series term: previous term times z, then divided by k through its reciprocal.
    assign w_tp   = {30'b0, r_term} * {31'b0, r_z};
    assign w_m    = rade_pkg::recip(r_k);
    assign w_prod = {r_ph, 17'b0} + {18'b0, r_pl};
    assign w_q    = w_prod[64:34];

    // Scale 100 * 2^f by 2^n and round half up.
    assign w_shift = rade_pkg::FRAC_Q - r_n[5:0];
    assign w_pw    = {9'b0, r_psum} * rade_pkg::CM_PER_M;
    assign w_rnd   = 40'd1 << (w_shift - 6'd1);
    assign w_v     = (w_pw + w_rnd) >> w_shift;
    assign w_dist  = (w_v > {16'b0, rade_pkg::DIST_MAX}) ? rade_pkg::DIST_MAX : w_v[23:0];

    assign w_load = !r_ovalid || !i_out_stall;

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wpos      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_div_start <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_new   <= i_head.rssi;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_sum       <= n_sum;
                    r_fill      <= n_fill;
                    r_wpos      <= (r_wpos == rade_pkg::PTR_W'(rade_pkg::DEPTH - 1)) ?
                                   '0 : r_wpos + 1'b1;
                    r_mneg      <= n_sum[rade_pkg::SUM_W-1];
                    r_div_num   <= rade_pkg::DIV_W'(w_sum_abs);
                    r_div_den   <= rade_pkg::DEN_W'(n_fill);
                    r_div_iters <= rade_pkg::ITER_W'(rade_pkg::SUM_W);
                    r_div_start <= 1'b1;
                    r_state     <= S_MDIV;
                end
                S_MDIV: begin
                    if (w_div_done) begin
                        r_mean  <= w_mean;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_yneg      <= w_diff[8];
                    r_div_num   <= w_mag;
                    r_div_den   <= (i_cfg.path_loss_divisor == '0) ?
                                   rade_pkg::DEN_W'(1) : i_cfg.path_loss_divisor;
                    r_div_iters <= rade_pkg::ITER_W'(rade_pkg::DIV_W);
                    r_div_start <= 1'b1;
                    r_state     <= S_YDIV;
                end
                S_YDIV: begin
                    if (w_div_done) begin
                        r_n     <= w_yrel[rade_pkg::DIV_W:32];
                        r_f     <= w_yrel[31:0];
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    if (r_n >= rade_pkg::N_HUGE) begin
                        r_dist  <= rade_pkg::DIST_MAX;
                        r_state <= S_OUT;
                    end else if (r_n <= rade_pkg::N_TINY) begin
                        r_dist  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_z     <= w_zp[63:34];
                        r_term  <= rade_pkg::ONE_Q30;
                        r_psum  <= rade_pkg::ONE_Q30;
                        r_k     <= rade_pkg::K_W'(1);
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    r_x     <= w_tp[59:30];
                    r_state <= S_TREC;
                end
                S_TREC: begin
                    r_ph    <= {18'b0, r_x} * {30'b0, w_m[34:17]};
                    r_pl    <= {17'b0, r_x} * {30'b0, w_m[16:0]};
                    r_state <= S_TACC;
                end
                S_TACC: begin
                    r_term <= w_q;
                    r_psum <= r_psum + w_q;
                    if (r_k == rade_pkg::K_W'(rade_pkg::TERMS)) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_TMUL;
                    end
                end
                S_SCALE: begin
                    r_dist  <= w_dist;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_ovalid              <= 1'b1;
                        r_odata.mean_rssi     <= r_mean;
                        r_odata.distance_cm   <= r_dist;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // Until the ring wraps, the write slot equals the number of stored samples.
    a_ring_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != rade_pkg::FILL_W'(rade_pkg::DEPTH)) |->
            (r_wpos == rade_pkg::PTR_W'(r_fill)))
        else $error("ring write slot out of step with fill count");

    // A finished quotient only arrives while the sequencer waits for it.
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_MDIV || r_state == S_YDIV))
        else $error("divider finished outside a wait state");

    // A result waiting behind a stalled output register is not dropped.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ovalid && i_out_stall) |=> (r_state == S_OUT))
        else $error("result left before the output register was free");

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the RSSI average distance estimator.
// Depends on design/rade_pkg.sv and design/rssi_average_distance_estimator.sv.
// Results are checked against a predictor of the sample ring, mean and fixed-point distance.
`timescale 1ns / 100ps

module testbench;

    // Predictor constants: ring depth, Q32 log2(10), Q32 ln(2), exponent bias, saturated distance, run limits.
    localparam int          RING_DEPTH   = rade_pkg::DEPTH;
    localparam logic [63:0] LOG2_TEN_Q32 = 64'h3_5269_E12F;
    localparam logic [63:0] LN_TWO_Q32   = 64'hB172_17F8;
    localparam logic [63:0] EXP_BIAS     = 64'd1024 << 32;
    localparam logic [63:0] FAR_CM       = 64'hFF_FFFF;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          SETTLE       = 300;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         psel        = 1'b0;
    logic                         penable     = 1'b0;
    logic                         pwrite      = 1'b0;
    logic [rade_pkg::ADDR_W-1:0]  paddr       = '0;
    logic [rade_pkg::DATA_W-1:0]  pwdata      = '0;
    logic [rade_pkg::DATA_W-1:0]  prdata;
    logic                         pready;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    rade_pkg::t_in                i_in_data   = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    rade_pkg::t_out               o_out_data;

    rssi_average_distance_estimator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the registers and the sample ring.
    logic [47:0]       tgt_addr = 48'd0;
    logic signed [7:0] ref_dbm  = -8'sd56;
    logic [6:0]        pl_div   = 7'd21;
    logic signed [7:0] ring [RING_DEPTH];
    int                ring_pos  = 0;
    int                ring_fill = 0;

    rade_pkg::t_in  beats_to_send [$];
    rade_pkg::t_out expected_results [$];

    int  errors          = 0;
    int  beats_sent      = 0;
    int  beats_matched   = 0;
    int  beats_ignored   = 0;
    int  results_checked = 0;
    int  settings_used   = 0;
    int  cycles          = 0;
    bit  beat_in_flight  = 1'b0;

    // Driver and monitor pacing state.
    int  gap_left      = 0;
    bit  drv_calm      = 1'b0;
    int  drv_calm_left = 0;
    int  hold_left     = 0;
    bit  mon_calm      = 1'b0;
    int  mon_calm_left = 0;

    // Log-distance estimate in cm for a dB difference, Q32 exponent and Q30 series.
    function automatic logic [23:0] distance_for(int diff);
        logic [63:0] dv, mag, y, f, z, sum, term, v;
        int          n, shift;
        dv  = (pl_div == 7'd0) ? 64'd1 : 64'(pl_div);
        mag = 64'(diff < 0 ? -diff : diff);
        mag = mag * LOG2_TEN_Q32;
        if (diff >= 0) begin
            y = EXP_BIAS + mag / dv;
        end else begin
            y = EXP_BIAS - (mag + dv - 64'd1) / dv;
        end
        n = int'(y[63:32]) - 1024;
        if (n >= 18) return FAR_CM[23:0];
        if (n <= -9) return 24'd0;
        f    = {32'd0, y[31:0]};
        z    = (f * LN_TWO_Q32) >> 34;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * z) >> 30) / 64'(k);
            sum  = sum + term;
        end
        shift = 30 - n;
        v = (64'd100 * sum + (64'd1 << (shift - 1))) >> shift;
        return (v > FAR_CM) ? FAR_CM[23:0] : v[23:0];
    endfunction

    // Update the ring for one accepted beat and queue the result it causes.
    task automatic track_sample(rade_pkg::t_in b);
        rade_pkg::t_out res;
        int             total, mean;
        beats_sent++;
        if (b.device_address != tgt_addr) begin
            beats_ignored++;
            return;
        end
        beats_matched++;
        ring[ring_pos] = b.rssi;
        ring_pos = (ring_pos + 1) % RING_DEPTH;
        if (ring_fill < RING_DEPTH) ring_fill++;
        total = 0;
        for (int i = 0; i < ring_fill; i++) total += ring[i];
        mean = total / ring_fill;
        res.mean_rssi   = 8'(mean);
        res.distance_cm = distance_for(int'(ref_dbm) - mean);
        expected_results.push_back(res);
    endtask

    function automatic rade_pkg::t_in beat(logic [47:0] a, logic signed [7:0] r);
        rade_pkg::t_in b;
        b.device_address = a;
        b.rssi           = r;
        return b;
    endfunction

    // Input driver: presents queued beats, with a random gap before each one.
    always @(posedge i_clk) begin : beat_driver
        logic busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                track_sample(i_in_data);
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (beats_to_send.size() > 0) begin
                    i_in_data <= beats_to_send.pop_front();
                    busy = 1'b1;
                    if (drv_calm_left == 0) begin
                        drv_calm      = ($urandom_range(0, 3) == 0);
                        drv_calm_left = $urandom_range(10, 40);
                    end
                    drv_calm_left--;
                    gap_left = drv_calm ? 0 : $urandom_range(0, 8);
                end
            end
            beat_in_flight = busy;
            i_in_valid <= busy;
        end
    end

    // Result monitor: compares each accepted result and stalls at random.
    always @(posedge i_clk) begin : result_monitor
        rade_pkg::t_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got mean %0d distance %0d",
                             $time, o_out_data.mean_rssi, o_out_data.distance_cm);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.mean_rssi !== want.mean_rssi) begin
                        errors++;
                        $display("%0t: mean_rssi mismatch, expected %0d, got %0d",
                                 $time, want.mean_rssi, o_out_data.mean_rssi);
                    end
                    if (o_out_data.distance_cm !== want.distance_cm) begin
                        errors++;
                        $display("%0t: distance_cm mismatch, expected %0d, got %0d",
                                 $time, want.distance_cm, o_out_data.distance_cm);
                    end
                end
                if (mon_calm_left == 0) begin
                    mon_calm      = ($urandom_range(0, 3) == 0);
                    mon_calm_left = $urandom_range(10, 40);
                end
                mon_calm_left--;
                hold_left = mon_calm ? 0 : $urandom_range(0, 8);
            end else if (hold_left == 0 && !o_out_valid && !mon_calm &&
                         $urandom_range(0, 15) == 0) begin
                // Raise a stall now and then while idle so it can meet a new result.
                hold_left = $urandom_range(1, 8);
            end
            i_out_stall <= (hold_left > 0);
            if (hold_left > 0) hold_left--;
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(logic [47:0] addr, logic signed [7:0] ref_v,
                                  logic [6:0] div_v);
        write_reg(rade_pkg::REG_TARGET, {16'd0, addr});
        write_reg(rade_pkg::REG_REF, {56'd0, ref_v});
        write_reg(rade_pkg::REG_PLD, {57'd0, div_v});
        tgt_addr = addr;
        ref_dbm  = ref_v;
        pl_div   = div_v;
        settings_used++;
    endtask

    // Wait until every beat is sent and every result is back, then let the block settle.
    task automatic wait_drained();
        while (beats_to_send.size() != 0 || beat_in_flight || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly beats for the tracked address, the rest near-miss or random addresses.
    task automatic queue_random_beats(int n_match);
        int                matched, kind, sel, base;
        logic [47:0]       a;
        logic signed [7:0] r;
        matched = 0;
        base = -int'($urandom_range(30, 100));
        while (matched < n_match) begin
            sel = $urandom_range(0, 19);
            if (sel < 10) begin
                r = 8'(base + int'($urandom_range(0, 12)) - 6);
            end else if (sel < 17) begin
                r = 8'($urandom);
            end else if (sel == 17) begin
                r = -8'sd128;
            end else if (sel == 18) begin
                r = 8'sd127;
            end else begin
                // Let the signal level drift.
                base = -int'($urandom_range(20, 110));
                r = 8'(base);
            end
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                a = tgt_addr;
            end else if (kind < 88) begin
                a = tgt_addr ^ (48'd1 << $urandom_range(0, 47));
            end else begin
                a = {16'($urandom), 32'($urandom)};
            end
            if (a == tgt_addr) matched++;
            beats_to_send.push_back(beat(a, r));
        end
    endtask

    task automatic run_random_phase(logic [47:0] addr, logic signed [7:0] ref_v,
                                    logic [6:0] div_v);
        apply_settings(addr, ref_v, div_v);
        queue_random_beats(36);
        wait_drained();
    endtask

    initial begin : stimulus
        logic [47:0] a;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        // Register defaults: extremes of rssi and near-miss addresses.
        beats_to_send.push_back(beat(48'h0, -8'sd128));
        beats_to_send.push_back(beat(48'h0, 8'sd127));
        beats_to_send.push_back(beat(48'h1, 8'sd10));
        beats_to_send.push_back(beat(48'h0, 8'sd0));
        beats_to_send.push_back(beat(48'hFFFF_FFFF_FFFF, -8'sd40));
        beats_to_send.push_back(beat(48'h0, -8'sd1));
        beats_to_send.push_back(beat(48'h8000_0000_0000, -8'sd60));
        beats_to_send.push_back(beat(48'h0, -8'sd56));
        wait_drained();

        // Divisor of one: the estimate saturates high for the first results.
        apply_settings(48'hFFFF_FFFF_FFFF, 8'sd0, 7'd1);
        beats_to_send.push_back(beat(48'hFFFF_FFFF_FFFF, -8'sd128));
        beats_to_send.push_back(beat(48'h7FFF_FFFF_FFFF, -8'sd128));
        beats_to_send.push_back(beat(48'hFFFF_FFFF_FFFF, -8'sd128));
        beats_to_send.push_back(beat(48'h0, 8'sd127));
        beats_to_send.push_back(beat(48'hFFFF_FFFF_FFFF, 8'sd127));
        wait_drained();

        // Lowest reference with strong samples: the estimate drops toward zero.
        a = {16'($urandom), 32'($urandom)};
        apply_settings(a, -8'sd128, 7'd100);
        beats_to_send.push_back(beat(a, 8'sd127));
        beats_to_send.push_back(beat(a, 8'sd127));
        beats_to_send.push_back(beat(a, -8'sd128));
        wait_drained();

        // Divisor of zero behaves as one.
        apply_settings(a, -8'sd128, 7'd0);
        beats_to_send.push_back(beat(a, 8'sd30));
        beats_to_send.push_back(beat(a, -8'sd5));
        beats_to_send.push_back(beat(a, 8'sd127));
        wait_drained();

        // Largest divisor the field holds.
        apply_settings(48'h5555_AAAA_5555, -8'sd60, 7'd127);
        beats_to_send.push_back(beat(48'h5555_AAAA_5555, -8'sd70));
        beats_to_send.push_back(beat(48'h5555_AAAA_5555, -8'sd40));
        beats_to_send.push_back(beat(48'hAAAA_5555_AAAA, -8'sd40));
        wait_drained();

        // Random beats under several settings, extremes among them.
        run_random_phase({16'($urandom), 32'($urandom)}, 8'(-int'($urandom_range(0, 128))),
                         7'($urandom_range(1, 100)));
        run_random_phase({16'($urandom), 32'($urandom)}, 8'sd0, 7'd100);
        run_random_phase({16'($urandom), 32'($urandom)}, -8'sd128, 7'd1);
        run_random_phase({16'($urandom), 32'($urandom)}, 8'(-int'($urandom_range(0, 128))),
                         7'd0);
        run_random_phase({16'($urandom), 32'($urandom)}, 8'sd127, 7'd127);
        run_random_phase({16'($urandom), 32'($urandom)}, 8'(-int'($urandom_range(0, 128))),
                         7'($urandom_range(1, 100)));
        run_random_phase({16'($urandom), 32'($urandom)}, 8'(-int'($urandom_range(0, 128))),
                         7'($urandom_range(1, 100)));
        run_random_phase({16'($urandom), 32'($urandom)}, -8'sd56, 7'd21);

        $display("Summary: %0d beats sent, %0d for the tracked address, %0d ignored.",
                 beats_sent, beats_matched, beats_ignored);
        $display("Checked %0d results under %0d register settings.",
                 results_checked, settings_used);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
